FILE: hw/rtl/byte_budget_packet_hold_queue_defines.svh
// assertion macros shared by the hold queue modules
// expects clk and rst_n in the scope of every use
`ifndef BYTE_BUDGET_PACKET_HOLD_QUEUE_DEFINES_SVH
`define BYTE_BUDGET_PACKET_HOLD_QUEUE_DEFINES_SVH

// same-cycle implication
`define BBQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bbq_pkg.sv
// shared constants, codes and types of the byte budget packet hold queue
// no dependencies
package bbq_pkg;

    localparam int RING_DEPTH  = 16384;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int RELEASE_CAP = 63;
    localparam int N_W         = 6;
    localparam int BUF_DEPTH   = 1 << N_W;
    localparam int USED_W      = 22;

    localparam int MODE_W   = 2;
    localparam int ID_W     = 32;
    localparam int LEN_W    = 16;
    localparam int GRANT_W  = 32;
    localparam int TIME_W   = 48;
    localparam int HELD_W   = 40;
    localparam int BUDGET_W = 48;
    localparam int INFLOW_W = 48;
    localparam int CAUSE_W  = 2;
    localparam int DELAY_W  = 32;

    localparam logic [DELAY_W-1:0] MAX_DELAY_RESET = 32'd25000000;

    localparam logic [MODE_W-1:0] MODE_ARRIVE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GRANT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

    localparam logic [CAUSE_W-1:0] CAUSE_OVERFLOW = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_AGE      = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_BUDGET   = 2'd2;

    typedef struct packed {
        logic               capture;
        logic               pop;
        logic [CAUSE_W-1:0] cause;
        logic               push;
        logic               grant;
        logic               clear_inflow;
        logic               settle;
        logic               emit_adv;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic overdue;
        logic cap_hit;
        logic budget_zero;
        logic budget_take;
        logic budget_stop;
        logic emit_last;
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] stamp;
    } slot_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [LEN_W-1:0]   len;
        logic [CAUSE_W-1:0] cause;
    } rel_t;

endpackage

FILE: hw/rtl/bbq_if.sv
// valid/ready channel interfaces for the hold queue input and result items
// depends on bbq_pkg
interface bbq_in_if;
    logic                          valid;
    logic                          ready;
    logic [bbq_pkg::MODE_W-1:0]    mode;
    logic [bbq_pkg::ID_W-1:0]      pkt_id;
    logic [bbq_pkg::LEN_W-1:0]     pkt_len;
    logic [bbq_pkg::GRANT_W-1:0]   grant_bytes;
    logic [bbq_pkg::TIME_W-1:0]    time_now;

    modport source (output valid, mode, pkt_id, pkt_len, grant_bytes, time_now,
                    input ready);
    modport sink   (input valid, mode, pkt_id, pkt_len, grant_bytes, time_now,
                    output ready);
endinterface

interface bbq_out_if;
    logic                          valid;
    logic                          ready;
    logic                          released;
    logic [bbq_pkg::ID_W-1:0]      released_id;
    logic [bbq_pkg::LEN_W-1:0]     released_len;
    logic [bbq_pkg::CAUSE_W-1:0]   release_cause;
    logic [bbq_pkg::HELD_W-1:0]    pressure;
    logic [bbq_pkg::BUDGET_W-1:0]  budget_left;
    logic [bbq_pkg::INFLOW_W-1:0]  inflow;
    logic                          last;

    modport source (output valid, released, released_id, released_len, release_cause,
                    pressure, budget_left, inflow, last, input ready);
    modport sink   (input valid, released, released_id, released_len, release_cause,
                    pressure, budget_left, inflow, last, output ready);
endinterface

FILE: hw/rtl/bbq_ctrl.sv
// controller state machine of the hold queue: sequences arrival, grant, tick and read
// depends on bbq_pkg and byte_budget_packet_hold_queue_defines.svh
`include "byte_budget_packet_hold_queue_defines.svh"

module bbq_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [bbq_pkg::MODE_W-1:0] in_mode,
    output logic                       in_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    input  bbq_pkg::status_t           st,
    output bbq_pkg::cmd_t              cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ARRIVE = 3'd1;
    localparam logic [2:0] S_GRANT  = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_AGE    = 3'd4;
    localparam logic [2:0] S_BUDGET = 3'd5;
    localparam logic [2:0] S_SETTLE = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (in_mode)
                        bbq_pkg::MODE_ARRIVE: state_next = S_ARRIVE;
                        bbq_pkg::MODE_GRANT:  state_next = S_GRANT;
                        bbq_pkg::MODE_TICK:   state_next = S_AGE;
                        bbq_pkg::MODE_READ:   state_next = S_READ;
                        default:              state_next = S_SETTLE;
                    endcase
                end
            end
            S_ARRIVE:
            begin
                // ring full: the oldest item leaves before the new one goes in
                cmd.push = 1'b1;
                if (st.full)
                begin
                    cmd.pop   = 1'b1;
                    cmd.cause = bbq_pkg::CAUSE_OVERFLOW;
                end
                state_next = S_SETTLE;
            end
            S_GRANT:
            begin
                cmd.grant  = 1'b1;
                state_next = S_SETTLE;
            end
            S_READ:
            begin
                cmd.clear_inflow = 1'b1;
                state_next       = S_SETTLE;
            end
            S_AGE:
            begin
                if (!st.empty && !st.cap_hit && st.overdue)
                begin
                    cmd.pop   = 1'b1;
                    cmd.cause = bbq_pkg::CAUSE_AGE;
                end
                else if (st.budget_zero)
                begin
                    state_next = S_SETTLE;
                end
                else
                begin
                    state_next = S_BUDGET;
                end
            end
            S_BUDGET:
            begin
                if (!st.empty && !st.cap_hit && st.budget_take)
                begin
                    cmd.pop   = 1'b1;
                    cmd.cause = bbq_pkg::CAUSE_BUDGET;
                    if (st.budget_stop)
                    begin
                        state_next = S_SETTLE;
                    end
                end
                else
                begin
                    state_next = S_SETTLE;
                end
            end
            S_SETTLE:
            begin
                cmd.settle = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    cmd.emit_adv = 1'b1;
                    if (st.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `BBQ_ASSERT_NEXT(a_accept_starts_work, in_valid && in_ready,
        state_reg != S_IDLE && state_reg != S_EMIT, "accepted item did not start work")
    `BBQ_ASSERT_NEXT(a_last_returns_idle, out_valid && out_ready && st.emit_last,
        state_reg == S_IDLE, "block not idle after last result")
    `BBQ_ASSERT_NOW(a_pop_in_work_state, cmd.pop,
        state_reg == S_ARRIVE || state_reg == S_AGE || state_reg == S_BUDGET,
        "ring pop outside a release state")

endmodule

FILE: hw/rtl/bbq_datapath.sv
// datapath of the hold queue: packet ring, byte counters, release buffer, result fields
// depends on bbq_pkg and byte_budget_packet_hold_queue_defines.svh
`include "byte_budget_packet_hold_queue_defines.svh"

module bbq_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bbq_pkg::cmd_t                 cmd,
    output bbq_pkg::status_t              st,
    input  logic [bbq_pkg::ID_W-1:0]      in_pkt_id,
    input  logic [bbq_pkg::LEN_W-1:0]     in_pkt_len,
    input  logic [bbq_pkg::GRANT_W-1:0]   in_grant_bytes,
    input  logic [bbq_pkg::TIME_W-1:0]    in_time_now,
    input  logic                          cfg_wr_en,
    input  logic [bbq_pkg::DELAY_W-1:0]   cfg_wr_data,
    output logic                          released,
    output logic [bbq_pkg::ID_W-1:0]      released_id,
    output logic [bbq_pkg::LEN_W-1:0]     released_len,
    output logic [bbq_pkg::CAUSE_W-1:0]   release_cause,
    output logic [bbq_pkg::HELD_W-1:0]    pressure,
    output logic [bbq_pkg::BUDGET_W-1:0]  budget_left,
    output logic [bbq_pkg::INFLOW_W-1:0]  inflow,
    output logic                          last
);

    localparam int AW = bbq_pkg::RING_AW;
    localparam int NW = bbq_pkg::N_W;
    localparam int UW = bbq_pkg::USED_W;
    localparam int HW = bbq_pkg::HELD_W;
    localparam int BW = bbq_pkg::BUDGET_W;
    localparam int IW = bbq_pkg::INFLOW_W;
    localparam int TW = bbq_pkg::TIME_W;
    localparam int LW = bbq_pkg::LEN_W;

    // storage
    bbq_pkg::slot_t ring_mem [bbq_pkg::RING_DEPTH];
    bbq_pkg::rel_t  rel_buf  [bbq_pkg::BUF_DEPTH];
    bbq_pkg::slot_t ring_rd_reg;
    bbq_pkg::rel_t  buf_rd_reg;

    logic [AW-1:0] head_reg, tail_reg, head_next, head_inc, tail_inc;
    logic [HW-1:0] held_reg, held_next, held_after_pop;
    logic [HW:0]   held_sum;
    logic [BW-1:0] budget_reg, budget_next;
    logic [BW:0]   budget_sum;
    logic [IW-1:0] inflow_reg, inflow_sat, rep_reg;
    logic [IW:0]   inflow_sum;
    logic [bbq_pkg::DELAY_W-1:0] max_delay_reg;
    logic [UW-1:0] used_reg;
    logic [UW:0]   used_sum;
    logic [NW-1:0] n_reg, emit_idx_reg, emit_idx_next, last_idx;
    logic [TW-1:0] age;

    // item fields
    logic [bbq_pkg::ID_W-1:0]    pkt_id_reg;
    logic [LW-1:0]               pkt_len_reg;
    logic [bbq_pkg::GRANT_W-1:0] grant_reg;
    logic [TW-1:0]               now_reg;

    assign head_inc  = (head_reg == AW'(bbq_pkg::RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == AW'(bbq_pkg::RING_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign head_next = cmd.pop ? head_inc : head_reg;

    // held bytes: clamp on release, saturate on arrival
    assign held_after_pop = !cmd.pop ? held_reg :
        ((held_reg < HW'(ring_rd_reg.len)) ? '0 : held_reg - HW'(ring_rd_reg.len));
    assign held_sum  = {1'b0, held_after_pop} + (HW + 1)'(pkt_len_reg);
    assign held_next = !cmd.push ? held_after_pop :
        (held_sum[HW] ? {HW{1'b1}} : held_sum[HW-1:0]);

    assign inflow_sum = {1'b0, inflow_reg} + (IW + 1)'(pkt_len_reg);
    assign inflow_sat = inflow_sum[IW] ? {IW{1'b1}} : inflow_sum[IW-1:0];

    assign budget_sum = {1'b0, budget_reg} + (BW + 1)'(grant_reg);

    always_comb
    begin
        budget_next = budget_reg;
        if (cmd.grant)
        begin
            budget_next = budget_sum[BW] ? {BW{1'b1}} : budget_sum[BW-1:0];
        end
        else if (cmd.settle)
        begin
            budget_next = (BW'(used_reg) > budget_reg) ? '0 : budget_reg - BW'(used_reg);
        end
    end

    assign used_sum = {1'b0, used_reg} + (UW + 1)'(ring_rd_reg.len);
    assign age      = now_reg - ring_rd_reg.stamp;

    assign emit_idx_next = cmd.capture  ? '0 :
                           cmd.emit_adv ? emit_idx_reg + 1'b1 : emit_idx_reg;
    assign last_idx      = (n_reg == '0) ? '0 : n_reg - 1'b1;

    assign st.empty       = (head_reg == tail_reg);
    assign st.full        = (tail_inc == head_reg);
    assign st.overdue     = (now_reg >= ring_rd_reg.stamp)
                            && (age >= TW'(max_delay_reg));
    assign st.cap_hit     = (n_reg == NW'(bbq_pkg::RELEASE_CAP));
    assign st.budget_zero = (budget_reg == '0);
    assign st.budget_take = (used_reg == '0) || (BW'(used_sum) <= budget_reg);
    assign st.budget_stop = (BW'(used_sum) >= budget_reg);
    assign st.emit_last   = (emit_idx_reg == last_idx);

    // ring read always follows the head, registered, so the head entry is ready in the cycle after the head moves
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            ring_mem[tail_reg] <= '{id: pkt_id_reg, len: pkt_len_reg, stamp: now_reg};
        end
        ring_rd_reg <= ring_mem[head_next];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            rel_buf[n_reg] <= '{id: ring_rd_reg.id, len: ring_rd_reg.len, cause: cmd.cause};
        end
        buf_rd_reg <= rel_buf[emit_idx_next];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pkt_id_reg  <= in_pkt_id;
            pkt_len_reg <= in_pkt_len;
            grant_reg   <= in_grant_bytes;
            now_reg     <= in_time_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            held_reg      <= '0;
            budget_reg    <= '0;
            inflow_reg    <= '0;
            rep_reg       <= '0;
            max_delay_reg <= bbq_pkg::MAX_DELAY_RESET;
            used_reg      <= '0;
            n_reg         <= '0;
            emit_idx_reg  <= '0;
        end
        else
        begin
            head_reg     <= head_next;
            held_reg     <= held_next;
            budget_reg   <= budget_next;
            emit_idx_reg <= emit_idx_next;
            if (cfg_wr_en)
            begin
                max_delay_reg <= cfg_wr_data;
            end
            if (cmd.push)
            begin
                tail_reg   <= tail_inc;
                inflow_reg <= inflow_sat;
                rep_reg    <= inflow_sat;
            end
            else if (cmd.clear_inflow)
            begin
                inflow_reg <= '0;
            end
            else if (cmd.capture)
            begin
                rep_reg <= inflow_reg;
            end
            if (cmd.capture)
            begin
                n_reg    <= '0;
                used_reg <= '0;
            end
            else if (cmd.pop)
            begin
                n_reg <= n_reg + 1'b1;
                if (cmd.cause == bbq_pkg::CAUSE_BUDGET)
                begin
                    used_reg <= used_sum[UW-1:0];
                end
            end
        end
    end

    // status-only result when nothing was released
    assign released      = (n_reg != '0);
    assign released_id   = released ? buf_rd_reg.id : '0;
    assign released_len  = released ? buf_rd_reg.len : '0;
    assign release_cause = released ? buf_rd_reg.cause : bbq_pkg::CAUSE_OVERFLOW;
    assign pressure      = held_reg;
    assign budget_left   = budget_reg;
    assign inflow        = rep_reg;
    assign last          = st.emit_last;

    `BBQ_ASSERT_NOW(a_pop_not_empty, cmd.pop, head_reg != tail_reg,
        "release from an empty ring")
    `BBQ_ASSERT_NOW(a_pop_under_cap, cmd.pop, n_reg < NW'(bbq_pkg::RELEASE_CAP),
        "release count past the cap")
    `BBQ_ASSERT_NEXT(a_push_not_empty, cmd.push, head_reg != tail_reg,
        "ring empty after an arrival")

endmodule

FILE: hw/rtl/byte_budget_packet_hold_queue.sv
// top level of the byte budget packet hold queue: controller plus datapath
// depends on bbq_pkg, bbq_if, bbq_ctrl and bbq_datapath
//
//   channel   dir   handshake       carries
//   in_ch     in    valid/ready     mode, pkt_id, pkt_len, grant_bytes, time_now
//   out_ch    out   valid/ready     released packet, cause, pressure, budget, inflow, last
//   cfg       in    cfg_wr_en       max_delay (32 bits)
//
// one item at a time: after accept, arrival, grant and read run a work state and settle;
// a tick releases one packet per cycle (one ring read port), by age, then by budget, and
// settles; results leave one per cycle from the release buffer; stalls on out_ch hold them
// reset clears pointers and counters at once, ring contents are not cleared

module byte_budget_packet_hold_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    bbq_in_if.sink                        in_ch,
    bbq_out_if.source                     out_ch,
    input  logic                          cfg_wr_en,
    input  logic [bbq_pkg::DELAY_W-1:0]   cfg_wr_data
);

    bbq_pkg::cmd_t    cmd;
    bbq_pkg::status_t st;

    bbq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_mode   (in_ch.mode),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .st        (st),
        .cmd       (cmd)
    );

    bbq_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .in_pkt_id      (in_ch.pkt_id),
        .in_pkt_len     (in_ch.pkt_len),
        .in_grant_bytes (in_ch.grant_bytes),
        .in_time_now    (in_ch.time_now),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .released       (out_ch.released),
        .released_id    (out_ch.released_id),
        .released_len   (out_ch.released_len),
        .release_cause  (out_ch.release_cause),
        .pressure       (out_ch.pressure),
        .budget_left    (out_ch.budget_left),
        .inflow         (out_ch.inflow),
        .last           (out_ch.last)
    );

endmodule
